### src/qhs_pkg.sv
// Shared types, constants and lookup functions for the quaternion heading smoother.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qhs_pkg;

  // Field widths
  localparam int unsigned QUAT_W     = 16;
  localparam int unsigned HEAD_W     = 15;
  localparam int unsigned SECT_W     = 3;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned THRESH_W   = 10;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_SHIFT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 1'd1;

  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 3'd2;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd32;

  // CORDIC sizing
  localparam int unsigned ATAN_ENTRIES     = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned STEP_W           = $clog2(ATAN_ENTRIES);
  localparam int unsigned ATAN_W           = 21;
  localparam int unsigned PROD_W           = 32;
  localparam int unsigned XY_W             = 37;
  localparam int unsigned Z_W              = 25;

  // Angle datapath widths
  localparam int unsigned YAW_W   = 16;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned MAG_W   = 14;
  localparam int unsigned NEWH_W  = 17;

  // Angles: 1/64 degree for headings, 1/16384 degree inside the CORDIC
  localparam int FULL_CIRCLE = 23040;
  localparam int HALF_CIRCLE = 11520;
  localparam int SECTOR_SPAN = 2880;
  localparam int SECTOR_HALF = 1440;
  localparam int ANGLE_180   = 180 * 16384;
  localparam int Q28_ONE     = 268435456;

  typedef struct packed {
    logic              load;
    logic              mul;
    logic              sum;
    logic              prep;
    logic              rot;
    logic [STEP_W-1:0] step;
    logic              yaw;
    logic              delta;
    logic              smooth;
    logic              commit;
  } qhs_cmd_t;

  typedef struct packed {
    logic out_busy;
  } qhs_sts_t;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 21'd737280;
      5'd1:    v = 21'd435242;
      5'd2:    v = 21'd229970;
      5'd3:    v = 21'd116736;
      5'd4:    v = 21'd58595;
      5'd5:    v = 21'd29326;
      5'd6:    v = 21'd14667;
      5'd7:    v = 21'd7334;
      5'd8:    v = 21'd3667;
      5'd9:    v = 21'd1833;
      5'd10:   v = 21'd917;
      5'd11:   v = 21'd458;
      5'd12:   v = 21'd229;
      5'd13:   v = 21'd115;
      5'd14:   v = 21'd57;
      5'd15:   v = 21'd29;
      5'd16:   v = 21'd14;
      5'd17:   v = 21'd7;
      5'd18:   v = 21'd4;
      5'd19:   v = 21'd2;
      5'd20:   v = 21'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // 45 degree compass sector, north centered on zero
  function automatic logic [SECT_W-1:0] sector_of(input logic [HEAD_W-1:0] head);
    logic [HEAD_W:0]   v;
    logic [SECT_W-1:0] s;
    v = {1'b0, head} + (HEAD_W+1)'(SECTOR_HALF);
    s = '0;
    for (int k = 1; k < 8; k++) begin
      if (v >= (HEAD_W+1)'(k * SECTOR_SPAN)) begin
        s = SECT_W'(k);
      end
    end
    // The wrap above 360 - 22.5 degrees falls back to north
    if (v >= (HEAD_W+1)'(8 * SECTOR_SPAN)) begin
      s = '0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### src/qhs_ctrl.sv
// Sequencer for the heading smoother: steps the datapath through one sample.
// Depends on qhs_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module qhs_ctrl #(
  parameter int unsigned CordicSteps = qhs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire qhs_pkg::qhs_sts_t sts_i,
  output qhs_pkg::qhs_cmd_t      cmd_o
);
  import qhs_pkg::*;

  localparam int unsigned EffSteps = (CordicSteps > ATAN_ENTRIES) ? ATAN_ENTRIES : CordicSteps;
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(EffSteps - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_PREP   = 4'd3;
  localparam logic [3:0] S_ROT    = 4'd4;
  localparam logic [3:0] S_YAW    = 4'd5;
  localparam logic [3:0] S_DELTA  = 4'd6;
  localparam logic [3:0] S_SMOOTH = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (step_q == LastStep) begin
          state_d = S_YAW;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_YAW: begin
        cmd_o.yaw = 1'b1;
        state_d   = S_DELTA;
      end
      S_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output slot is free or frees this cycle
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

### src/qhs_datapath.sv
// Datapath for the heading smoother: products, shared CORDIC shift-add unit,
// heading filter, emit decision, output register. Depends on qhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qhs_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [qhs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [qhs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0]   quat_i_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0]   quat_j_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0]   quat_k_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0]   quat_real_i,
  input  wire qhs_pkg::qhs_cmd_t                   cmd_i,
  output qhs_pkg::qhs_sts_t                        sts_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [qhs_pkg::HEAD_W-1:0]               heading_o,
  output logic [qhs_pkg::SECT_W-1:0]               sector_o
);
  import qhs_pkg::*;

  localparam logic signed [XY_W-1:0]    XyQ28One   = XY_W'(Q28_ONE);
  localparam logic signed [Z_W-1:0]     ZHalfTurn  = Z_W'(ANGLE_180);
  localparam logic signed [Z_W-1:0]     ZRound     = Z_W'(128);
  localparam logic signed [YAW_W-1:0]   YawFull    = YAW_W'(FULL_CIRCLE);
  localparam logic signed [DELTA_W-1:0] DeltaFull  = DELTA_W'(FULL_CIRCLE);
  localparam logic signed [DELTA_W-1:0] DeltaHalf  = DELTA_W'(HALF_CIRCLE);
  localparam logic signed [NEWH_W-1:0]  NewhFull   = NEWH_W'(FULL_CIRCLE);

  // configuration
  logic [SHIFT_W-1:0]  shift_q;
  logic [THRESH_W-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= SHIFT_RESET;
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SMOOTHING_SHIFT:  shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_CHANGE_THRESHOLD: thresh_q <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // sample and products
  logic signed [QUAT_W-1:0] qi_q, qj_q, qk_q, qr_q;
  logic signed [PROD_W-1:0] p_rk_q, p_ij_q, p_jj_q, p_kk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qi_q <= quat_i_i;
      qj_q <= quat_j_i;
      qk_q <= quat_k_i;
      qr_q <= quat_real_i;
    end
    if (cmd_i.mul) begin
      p_rk_q <= PROD_W'(qr_q) * PROD_W'(qk_q);
      p_ij_q <= PROD_W'(qi_q) * PROD_W'(qj_q);
      p_jj_q <= PROD_W'(qj_q) * PROD_W'(qj_q);
      p_kk_q <= PROD_W'(qk_q) * PROD_W'(qk_q);
    end
  end

  // CORDIC vectoring unit, one rotation per cycle
  logic signed [XY_W-1:0] x_q, y_q, x_d, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic                   zero_q;
  logic signed [XY_W-1:0] xs, ys, sy, cy;
  logic signed [Z_W-1:0]  atan_s;

  assign sy     = (XY_W'(p_rk_q) + XY_W'(p_ij_q)) <<< 1;
  assign cy     = XyQ28One - ((XY_W'(p_jj_q) + XY_W'(p_kk_q)) <<< 1);
  assign xs     = x_q >>> cmd_i.step;
  assign ys     = y_q >>> cmd_i.step;
  assign atan_s = Z_W'(atan_lut(cmd_i.step));

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cmd_i.sum) begin
      x_d = cy;
      y_d = sy;
    end else if (cmd_i.prep) begin
      // left half plane: reflect and start from +-180 degrees
      if (x_q < 0) begin
        x_d = -x_q;
        y_d = -y_q;
        z_d = (y_q >= 0) ? ZHalfTurn : -ZHalfTurn;
      end else begin
        z_d = '0;
      end
    end else if (cmd_i.rot) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (cmd_i.prep) begin
      zero_q <= (x_q == '0) && (y_q == '0);
    end
  end

  // yaw in 1/64 degree, wrapped into one turn
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [YAW_W-1:0] yaw_s, yaw_w;
  logic [HEAD_W-1:0]       yaw_q;

  assign z_rnd = (z_q + ZRound) >>> 8;
  assign yaw_s = z_rnd[YAW_W-1:0];
  assign yaw_w = (yaw_s < 0) ? (yaw_s + YawFull) : yaw_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.yaw) begin
      yaw_q <= zero_q ? '0 : yaw_w[HEAD_W-1:0];
    end
  end

  // shortest signed difference, scaled toward zero
  logic [HEAD_W-1:0]        smooth_q, last_q;
  logic                     has_emitted_q;
  logic signed [DELTA_W-1:0] delta_raw, delta_w;
  logic [MAG_W-1:0]          mag, step_mag;
  logic signed [HEAD_W-1:0]  step_q;

  always_comb begin
    delta_raw = $signed({1'b0, yaw_q}) - $signed({1'b0, smooth_q});
    delta_w   = delta_raw;
    if (delta_raw > DeltaHalf) begin
      delta_w = delta_raw - DeltaFull;
    end else if (delta_raw < -DeltaHalf) begin
      delta_w = delta_raw + DeltaFull;
    end
    mag      = (delta_w < 0) ? MAG_W'(-delta_w) : MAG_W'(delta_w);
    step_mag = mag >> shift_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.delta) begin
      step_q <= (delta_w < 0) ? -$signed(HEAD_W'(step_mag)) : $signed(HEAD_W'(step_mag));
    end
  end

  // filter update, then emit decision
  logic signed [NEWH_W-1:0] newh, newh_w;
  logic signed [DELTA_W-1:0] diff;
  logic [HEAD_W-1:0]         diff_abs;
  logic                      emit;

  always_comb begin
    newh   = $signed(NEWH_W'(smooth_q)) + NEWH_W'(step_q);
    newh_w = newh;
    if (newh < 0) begin
      newh_w = newh + NewhFull;
    end else if (newh >= NewhFull) begin
      newh_w = newh - NewhFull;
    end
    diff     = $signed({1'b0, smooth_q}) - $signed({1'b0, last_q});
    diff_abs = (diff < 0) ? HEAD_W'(-diff) : HEAD_W'(diff);
    emit     = !has_emitted_q || (diff_abs >= HEAD_W'(thresh_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q      <= '0;
      last_q        <= '0;
      has_emitted_q <= 1'b0;
    end else begin
      if (cmd_i.smooth) begin
        smooth_q <= newh_w[HEAD_W-1:0];
      end
      if (cmd_i.commit && emit) begin
        last_q        <= smooth_q;
        has_emitted_q <= 1'b1;
      end
    end
  end

  // output register
  logic                  out_valid_q;
  logic [HEAD_W-1:0]     heading_q;
  logic [SECT_W-1:0]     sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && emit) begin
      heading_q <= smooth_q;
      sector_q  <= sector_of(smooth_q);
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign heading_o      = heading_q;
  assign sector_o       = sector_q;

endmodule

`default_nettype wire

### src/quaternion_heading_smoother_unit.sv
// An input beat passes through the products, sums, half-plane fold, rotation loop, yaw,
//   difference, filter and emit steps to the output register; samples under threshold give no beat.
// A new sample is taken only once the previous one has left the emit step; most of a pass is the
//   CORDIC rotation loop, which runs one shift-add step per cycle on a single shared unit.
// Reset (async, active low): idle, smoothed and last headings zero, nothing emitted yet,
//   smoothing_shift = 2, change_threshold = 32.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_heading_smoother_unit #(
  parameter int unsigned CordicSteps = qhs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port, used only while idle (the block itself does not enforce this)
  input  wire logic                              cfg_we_i,
  input  wire logic [qhs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [qhs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0] quat_i_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0] quat_j_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0] quat_k_i,
  input  wire logic signed [qhs_pkg::QUAT_W-1:0] quat_real_i,
  // heading channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [qhs_pkg::HEAD_W-1:0]             heading_o,
  output logic [qhs_pkg::SECT_W-1:0]             sector_o
);
  import qhs_pkg::*;

  // The sequencer walks a sample through: latch, four products, operand sums,
  // half-plane fold, the rotation loop, yaw rounding, wrapped difference,
  // filter update and finally the emit decision. The emit step holds while a
  // previous heading beat still sits unread in the output register; a new
  // sample beat is taken as soon as the sequencer is back at rest, even if that
  // output beat is still waiting.
  qhs_cmd_t cmd;
  qhs_sts_t sts;

  qhs_ctrl #(
    .CordicSteps(CordicSteps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath owns the configuration, the filter state and the output register.
  qhs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .quat_i_i    (quat_i_i),
    .quat_j_i    (quat_j_i),
    .quat_k_i    (quat_k_i),
    .quat_real_i (quat_real_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .heading_o   (heading_o),
    .sector_o    (sector_o)
  );

endmodule

`default_nettype wire

### dv/tb_quaternion_heading_smoother_unit.sv
// Testbench for quaternion_heading_smoother_unit: random quaternion beats in, headings out.
// Predicts heading beats with its own CORDIC/smoothing model; depends on qhs_pkg and the unit.
`timescale 1ns / 1ps

module tb_quaternion_heading_smoother_unit;
  import qhs_pkg::*;

  // Run limits, in clock cycles
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  // Margin for a sample that emits nothing to finish its pass through the block
  localparam int unsigned SETTLE_WAIT  = 40;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned PHASE_CAP    = 150;
  localparam int unsigned PHASE_BEATS  = 8;
  localparam int unsigned CORDIC_N     = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;

  localparam logic [SECT_W-1:0] SECTOR_NORTH = 3'd0;

  // atan(2^-n) in 1/16384 degree, rounded to nearest
  localparam longint ATAN_UNITS [24] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [SECT_W-1:0] sect;
  } heading_beat_t;

  // One directed sample. A row marked reprogram drains the block and loads new settings
  // first; a row marked typed carries its result as read straight off the spec.
  typedef struct packed {
    logic                     reprogram;
    logic [SHIFT_W-1:0]       shift;
    logic [THRESH_W-1:0]      thresh;
    logic signed [QUAT_W-1:0] qi;
    logic signed [QUAT_W-1:0] qj;
    logic signed [QUAT_W-1:0] qk;
    logic signed [QUAT_W-1:0] qr;
    logic                     typed;
    logic [HEAD_W-1:0]        head;
    logic [SECT_W-1:0]        sect;
  } steer_row_t;

  localparam int STEER_N = 20;
  localparam steer_row_t STEER_ROWS [STEER_N] = '{
    // reset settings: the zero vector gives yaw 0, and the first sample always emits
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 1'b1, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, -16'sd11585, 16'sd11585, 1'b0, 15'd0, SECTOR_NORTH},
    // no smoothing, zero threshold: heading follows yaw and every sample emits
    '{1'b1, 3'd0, 10'd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 1'b1, 15'd0, SECTOR_NORTH},
    // x negative with y zero: a full half-circle step from north
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, 15'd0, SECTOR_NORTH},
    // and back by a half circle the other way
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 1'b1, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
      1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
      1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000,
      1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767,
      1'b0, 15'd0, SECTOR_NORTH},
    // x and y both negative: the CORDIC starts from -180
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, 16'sd16384, -16'sd1, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, 15'd0, SECTOR_NORTH},
    // heaviest smoothing and largest threshold: the step truncates toward zero
    '{1'b1, 3'd7, 10'd1023, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585,
      1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd0, -16'sd11585, 16'sd11585, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b1, 3'd3, 10'd1, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, 15'd0, SECTOR_NORTH},
    '{1'b0, 3'd0, 10'd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 1'b0, 15'd0, SECTOR_NORTH}
  };

  // Settings for the random phases, extremes included
  localparam int RAND_PHASES = 10;
  localparam logic [SHIFT_W-1:0]  PHASE_SHIFT  [RAND_PHASES] = '{
    3'd0, 3'd7, 3'd1, 3'd7, 3'd0, 3'd4, 3'd2, 3'd5, 3'd3, 3'd6
  };
  localparam logic [THRESH_W-1:0] PHASE_THRESH [RAND_PHASES] = '{
    10'd0, 10'd1023, 10'd16, 10'd0, 10'd1023, 10'd3, 10'd32, 10'd200, 10'd0, 10'd64
  };

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [QUAT_W-1:0] quat_i_i    = '0;
  logic signed [QUAT_W-1:0] quat_j_i    = '0;
  logic signed [QUAT_W-1:0] quat_k_i    = '0;
  logic signed [QUAT_W-1:0] quat_real_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [HEAD_W-1:0]        heading_o;
  logic [SECT_W-1:0]        sector_o;

  quaternion_heading_smoother_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .quat_i_i    (quat_i_i),
    .quat_j_i    (quat_j_i),
    .quat_k_i    (quat_k_i),
    .quat_real_i (quat_real_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .heading_o   (heading_o),
    .sector_o    (sector_o)
  );

  // Predicted state of the smoother
  logic [SHIFT_W-1:0]  cur_shift  = SHIFT_RESET;
  logic [THRESH_W-1:0] cur_thresh = THRESH_RESET;
  int                  smooth_head    = 0;
  int                  last_sent_head = 0;
  bit                  sent_any       = 1'b0;

  heading_beat_t pending_headings[$];
  heading_beat_t want_beat;
  int unsigned   mismatches = 0;
  int unsigned   beats_seen = 0;
  int unsigned   cycles     = 0;
  int unsigned   stall_left = 0;
  bit            quiet_run  = 1'b0;
  logic signed [QUAT_W-1:0] drift_k = 16'sd0;
  logic signed [QUAT_W-1:0] drift_r = 16'sd16384;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop on a hung handshake
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quaternion_heading_smoother_unit NOT OK");
      $finish;
    end
  end

  function automatic int fold_to_circle(input longint v);
    longint m;
    m = v % FULL_CIRCLE;
    if (m < 0) m += FULL_CIRCLE;
    return int'(m);
  endfunction

  // Advance the predicted smoother by one sample; return 1 when a heading beat is due.
  function automatic bit advance_heading(input logic signed [QUAT_W-1:0] qi_f,
                                         input logic signed [QUAT_W-1:0] qj_f,
                                         input logic signed [QUAT_W-1:0] qk_f,
                                         input logic signed [QUAT_W-1:0] qr_f,
                                         output heading_beat_t beat);
    longint qi, qj, qk, qr, vy, vx, ang, xs, ys;
    int     yaw, delta, mag, stp, diff;
    qi = qi_f;
    qj = qj_f;
    qk = qk_f;
    qr = qr_f;
    beat = '0;
    // Q28 operands of atan2
    vy = 2 * (qr * qk + qi * qj);
    vx = longint'(Q28_ONE) - 2 * (qj * qj + qk * qk);
    ang = 0;
    // The zero vector keeps yaw at 0
    if (vx != 0 || vy != 0) begin
      // Fold the left half-plane over, starting from +-180 degrees
      if (vx < 0) begin
        ang = (vy >= 0) ? longint'(ANGLE_180) : -longint'(ANGLE_180);
        vx = -vx;
        vy = -vy;
      end
      for (int n = 0; n < CORDIC_N; n++) begin
        xs = vx >>> n;
        ys = vy >>> n;
        if (vy > 0) begin
          vx  = vx + ys;
          vy  = vy - xs;
          ang = ang + ATAN_UNITS[n];
        end else begin
          vx  = vx - ys;
          vy  = vy + xs;
          ang = ang - ATAN_UNITS[n];
        end
      end
    end
    // 1/16384 degree to 1/64 degree, rounded by floor after adding half
    yaw = fold_to_circle((ang + 128) >>> 8);

    // Shortest signed difference; exactly +-180 is left alone
    delta = yaw - smooth_head;
    if (delta > HALF_CIRCLE) delta -= FULL_CIRCLE;
    if (delta < -HALF_CIRCLE) delta += FULL_CIRCLE;
    mag = (delta < 0) ? -delta : delta;
    stp = mag >> cur_shift;
    if (delta < 0) stp = -stp;
    smooth_head = fold_to_circle(longint'(smooth_head) + stp);

    // Plain difference against the last emitted heading, no wrap
    diff = smooth_head - last_sent_head;
    if (diff < 0) diff = -diff;
    if (sent_any && diff < int'(cur_thresh)) return 1'b0;

    last_sent_head = smooth_head;
    sent_any       = 1'b1;
    beat.head      = HEAD_W'(smooth_head);
    beat.sect      = SECT_W'((smooth_head + SECTOR_HALF) / SECTOR_SPAN);
    return 1'b1;
  endfunction

  // Idle lengths: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [QUAT_W-1:0] corner_value();
    case ($urandom_range(0, 6))
      0:       return 16'sh8000;
      1:       return -16'sd16384;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd16384;
      default: return 16'sd32767;
    endcase
  endfunction

  // Heading beats: check against the oldest prediction, stall the receiver at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen <= beats_seen + 1;
      if (pending_headings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected heading beat: heading %0d sector %0d", heading_o, sector_o);
      end else begin
        want_beat = pending_headings.pop_front();
        if (heading_o !== want_beat.head || sector_o !== want_beat.sect) begin
          mismatches++;
          if (mismatches <= 10)
            $display("heading beat %0d: expected heading %0d sector %0d, got %0d sector %0d",
                     beats_seen, want_beat.head, want_beat.sect, heading_o, sector_o);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet_run && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // Hold off until every predicted heading has come back
  task automatic wait_drained();
    while (pending_headings.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a sample that emits nothing finish its pass through the CORDIC
  task automatic settle_block();
    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Load both registers while idle and mirror them in the predictor
  task automatic apply_settings(input logic [SHIFT_W-1:0] shift,
                                input logic [THRESH_W-1:0] thresh);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SMOOTHING_SHIFT;
    cfg_data_i <= CFG_DATA_W'(shift);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CHANGE_THRESHOLD;
    cfg_data_i <= CFG_DATA_W'(thresh);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_shift  = shift;
    cur_thresh = thresh;
  endtask

  // Drop valid for a random gap before the next beat
  task automatic pace_sender();
    int unsigned gap;
    gap = quiet_run ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Present one sample, hold it until accepted, then predict its heading
  task automatic send_beat(input logic signed [QUAT_W-1:0] qi,
                           input logic signed [QUAT_W-1:0] qj,
                           input logic signed [QUAT_W-1:0] qk,
                           input logic signed [QUAT_W-1:0] qr,
                           input bit typed, input heading_beat_t typed_beat);
    heading_beat_t pred;
    bit            emit;
    in_valid_i  <= 1'b1;
    quat_i_i    <= qi;
    quat_j_i    <= qj;
    quat_k_i    <= qk;
    quat_real_i <= qr;
    do @(posedge clk_i); while (!in_ready_o);
    emit = advance_heading(qi, qj, qk, qr, pred);
    if (emit) pending_headings.push_back(typed ? typed_beat : pred);
  endtask

  // Random sample: mostly yaw-dominant or slowly drifting orientations, the rest noise, corners and zero vectors
  task automatic pick_sample(output logic signed [QUAT_W-1:0] qi,
                             output logic signed [QUAT_W-1:0] qj,
                             output logic signed [QUAT_W-1:0] qk,
                             output logic signed [QUAT_W-1:0] qr);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 40) begin
      qi = QUAT_W'(int'($urandom_range(0, 4000)) - 2000);
      qj = QUAT_W'(int'($urandom_range(0, 4000)) - 2000);
      qk = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
      qr = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
    end else if (mode < 60) begin
      // slow turn: small steps let the smoothing settle and the threshold matter
      drift_k = drift_k + QUAT_W'(int'($urandom_range(0, 1200)) - 600);
      drift_r = drift_r + QUAT_W'(int'($urandom_range(0, 1200)) - 600);
      qi = QUAT_W'(int'($urandom_range(0, 600)) - 300);
      qj = QUAT_W'(int'($urandom_range(0, 600)) - 300);
      qk = drift_k;
      qr = drift_r;
    end else if (mode < 80) begin
      qi = QUAT_W'($urandom);
      qj = QUAT_W'($urandom);
      qk = QUAT_W'($urandom);
      qr = QUAT_W'($urandom);
    end else if (mode < 90) begin
      qi = corner_value();
      qj = corner_value();
      qk = corner_value();
      qr = corner_value();
    end else begin
      // zero vector family: j = k = +-8192 and real = -i cancel both atan2 operands
      qj = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
      qk = qj;
      qi = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
      qr = -qi;
    end
  endtask

  initial begin
    logic signed [QUAT_W-1:0] qi, qj, qk, qr;
    heading_beat_t            typed_beat;
    int unsigned              n, phase_start;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    for (int r = 0; r < STEER_N; r++) begin
      if (STEER_ROWS[r].reprogram) begin
        in_valid_i <= 1'b0;
        settle_block();
        apply_settings(STEER_ROWS[r].shift, STEER_ROWS[r].thresh);
      end else begin
        pace_sender();
      end
      typed_beat.head = STEER_ROWS[r].head;
      typed_beat.sect = STEER_ROWS[r].sect;
      send_beat(STEER_ROWS[r].qi, STEER_ROWS[r].qj, STEER_ROWS[r].qk, STEER_ROWS[r].qr,
                STEER_ROWS[r].typed, typed_beat);
    end

    // Random phases, one setting each; keep going where headings are rare
    for (int p = 0; p < RAND_PHASES; p++) begin
      in_valid_i <= 1'b0;
      settle_block();
      apply_settings(PHASE_SHIFT[p], PHASE_THRESH[p]);
      phase_start = beats_seen;
      n = 0;
      while (n < PHASE_ITEMS ||
             (beats_seen - phase_start < PHASE_BEATS && n < PHASE_CAP)) begin
        if (n % 50 == 0) quiet_run = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) == 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end else begin
          pace_sender();
        end
        pick_sample(qi, qj, qk, qr);
        send_beat(qi, qj, qk, qr, 1'b0, '0);
        n++;
      end
    end

    // Drain what is still in flight, then allow one more pass through the block
    in_valid_i <= 1'b0;
    quiet_run = 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending_headings.size() != 0; k++) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);

    if (mismatches == 0 && pending_headings.size() == 0) begin
      $display("tb_quaternion_heading_smoother_unit OK");
    end else begin
      $display("tb_quaternion_heading_smoother_unit NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/qhs_pkg.sv
src/qhs_ctrl.sv
src/qhs_datapath.sv
src/quaternion_heading_smoother_unit.sv
dv/tb_quaternion_heading_smoother_unit.sv
